// ===== rtl/region_intrusion_classifier_macros.svh =====
// Assertion shorthands for the region intrusion classifier.
// Both sample on clk_i and are switched off while rst_ni is low.
`ifndef REGION_INTRUSION_CLASSIFIER_MACROS_SVH
`define REGION_INTRUSION_CLASSIFIER_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define RIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the following cycle.
`define RIC_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ric_pkg.sv =====
package ric_pkg;

  localparam int unsigned CFG_W      = 12;
  localparam int unsigned AREA_W     = 23;
  localparam int unsigned RUN_W      = 4;
  localparam int unsigned MASK_W     = 8;
  localparam int unsigned CODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [AREA_W-1:0] AREA_CAP = 23'd4194304;
  localparam logic [RUN_W-1:0]  RUN_CAP  = 4'd15;

  // Register reset values.
  localparam logic [CFG_W-1:0]  FRAME_WIDTH_RST = 12'd640;
  localparam logic [CFG_W-1:0]  COL_START_RST   = 12'd213;
  localparam logic [CFG_W-1:0]  COL_END_RST     = 12'd426;
  localparam logic [CFG_W-1:0]  ROW_START_RST   = 12'd160;
  localparam logic [CFG_W-1:0]  ROW_END_RST     = 12'd320;
  localparam logic [AREA_W-1:0] LARGE_THR_RST   = 23'd600;
  localparam logic [AREA_W-1:0] SMALL_THR_RST   = 23'd100;
  localparam logic [RUN_W-1:0]  PERSIST_RST     = 4'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_COL_START,
    REG_COL_END,
    REG_ROW_START,
    REG_ROW_END,
    REG_LARGE_THR,
    REG_SMALL_THR,
    REG_PERSIST
  } cfg_reg_e;

  localparam logic [CODE_W-1:0] CLASS_NONE  = 2'd0;
  localparam logic [CODE_W-1:0] CLASS_SMALL = 2'd1;
  localparam logic [CODE_W-1:0] CLASS_LARGE = 2'd2;

  localparam logic [CODE_W-1:0] ALARM_NONE    = 2'd0;
  localparam logic [CODE_W-1:0] ALARM_PERSON  = 2'd1;
  localparam logic [CODE_W-1:0] ALARM_VEHICLE = 2'd2;

  typedef struct packed {
    logic [MASK_W-1:0] mask_value;
    logic              end_of_frame;
  } pix_t;

  typedef struct packed {
    logic [AREA_W-1:0] region_area;
    logic [CODE_W-1:0] frame_class;
    logic [CODE_W-1:0] alarm_kind;
  } res_t;

endpackage

// ===== rtl/ric_channels.sv =====
interface ric_pix_if;
  logic          valid;
  logic          ready;
  ric_pkg::pix_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ric_res_if;
  logic          valid;
  logic          ready;
  ric_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/region_intrusion_classifier.sv =====
// Region intrusion classifier.
// pix_i takes foreground-mask pixels in raster order, one request per pixel;
// the block keeps its own column and row count and counts nonzero pixels
// inside the configured rectangle. The request flagged end_of_frame closes
// the frame: res_o then carries one request with the frame's area, its
// class and any alarm. Other pixels produce nothing on res_o.
// A pixel is taken in every cycle while the skid stage is empty; the result
// of an end-of-frame pixel is registered into the output register when that
// is free, else into the skid stage. All per-pixel work is one increment and
// a few compares, so the rate is one pixel per clock while the skid is empty.
// When the receiver stalls, one more result parks in the skid stage and
// pix_i.ready drops until the output register drains.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
// must write them only while the block is idle; it does not enforce this.
// An asynchronous reset (rst_ni low) loads the register defaults, clears
// position, area and run counts, and empties the output and skid stages.
`include "region_intrusion_classifier_macros.svh"

module region_intrusion_classifier #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ric_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ric_pkg::AREA_W-1:0]       cfg_wdata_i,
  ric_pix_if.sink                          pix_i,
  ric_res_if.source                        res_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned CMPW  = (CW + 1 > ric_pkg::CFG_W) ? CW + 1 : ric_pkg::CFG_W;
  localparam int unsigned RCMPW = (RW > ric_pkg::CFG_W) ? RW : ric_pkg::CFG_W;

  // Configuration registers.
  logic [ric_pkg::CFG_W-1:0]  frame_width_q, col_start_q, col_end_q;
  logic [ric_pkg::CFG_W-1:0]  row_start_q, row_end_q;
  logic [ric_pkg::AREA_W-1:0] large_thr_q, small_thr_q;
  logic [ric_pkg::RUN_W-1:0]  persist_q;

  // Frame state.
  logic [CW-1:0]              col_q, col_d;
  logic [RW-1:0]              row_q, row_d;
  logic [ric_pkg::AREA_W-1:0] area_q, area_d, area_nxt;
  logic [ric_pkg::RUN_W-1:0]  lrun_q, lrun_d, srun_q, srun_d;
  logic [ric_pkg::RUN_W-1:0]  lrun_bump, srun_bump;

  // Output register and skid stage.
  logic          out_valid_q, skid_valid_q;
  ric_pkg::res_t out_q, skid_q, res_new;

  logic              pix_acc, eof_acc, out_free;
  logic [CMPW-1:0]   col_ext, col_inc;
  logic [RCMPW-1:0]  row_ext;
  logic              wrap, row_last, hit;

  assign pix_i.ready = !skid_valid_q;
  assign pix_acc     = pix_i.valid && pix_i.ready;
  assign eof_acc     = pix_acc && pix_i.data.end_of_frame;
  assign out_free    = !out_valid_q || res_o.ready;

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= ric_pkg::FRAME_WIDTH_RST;
      col_start_q   <= ric_pkg::COL_START_RST;
      col_end_q     <= ric_pkg::COL_END_RST;
      row_start_q   <= ric_pkg::ROW_START_RST;
      row_end_q     <= ric_pkg::ROW_END_RST;
      large_thr_q   <= ric_pkg::LARGE_THR_RST;
      small_thr_q   <= ric_pkg::SMALL_THR_RST;
      persist_q     <= ric_pkg::PERSIST_RST;
    end else if (cfg_we_i) begin
      case (ric_pkg::cfg_reg_e'(cfg_idx_i))
        ric_pkg::REG_FRAME_WIDTH: frame_width_q <= cfg_wdata_i[ric_pkg::CFG_W-1:0];
        ric_pkg::REG_COL_START:   col_start_q   <= cfg_wdata_i[ric_pkg::CFG_W-1:0];
        ric_pkg::REG_COL_END:     col_end_q     <= cfg_wdata_i[ric_pkg::CFG_W-1:0];
        ric_pkg::REG_ROW_START:   row_start_q   <= cfg_wdata_i[ric_pkg::CFG_W-1:0];
        ric_pkg::REG_ROW_END:     row_end_q     <= cfg_wdata_i[ric_pkg::CFG_W-1:0];
        ric_pkg::REG_LARGE_THR:   large_thr_q   <= cfg_wdata_i;
        ric_pkg::REG_SMALL_THR:   small_thr_q   <= cfg_wdata_i;
        ric_pkg::REG_PERSIST:     persist_q     <= cfg_wdata_i[ric_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Position, region test and area count.
  always_comb begin
    col_ext  = CMPW'(col_q);
    col_inc  = col_ext + CMPW'(1);
    row_ext  = RCMPW'(row_q);
    // A zero frame width behaves as width one since col_inc is never zero.
    wrap     = (col_inc >= CMPW'(frame_width_q)) || (col_inc >= CMPW'(MAX_WIDTH));
    row_last = (row_q == RW'(MAX_HEIGHT - 1));
    hit      = (pix_i.data.mask_value != '0) &&
               (col_ext >= CMPW'(col_start_q)) && (col_ext < CMPW'(col_end_q)) &&
               (row_ext >= RCMPW'(row_start_q)) && (row_ext < RCMPW'(row_end_q));
    area_nxt = (hit && (area_q < ric_pkg::AREA_CAP)) ? area_q + 1'b1 : area_q;
  end

  // Frame close: classification and run counts; next position and area.
  always_comb begin
    lrun_bump = (lrun_q < ric_pkg::RUN_CAP) ? lrun_q + 1'b1 : ric_pkg::RUN_CAP;
    srun_bump = (srun_q < ric_pkg::RUN_CAP) ? srun_q + 1'b1 : ric_pkg::RUN_CAP;

    res_new.region_area = area_nxt;
    res_new.alarm_kind  = ric_pkg::ALARM_NONE;
    lrun_d = lrun_q;
    srun_d = srun_q;

    // The large test comes first, so overlapping thresholds favor large.
    if (area_nxt > large_thr_q) begin
      res_new.frame_class = ric_pkg::CLASS_LARGE;
      srun_d = '0;
      lrun_d = lrun_bump;
      if (lrun_bump > persist_q) begin
        res_new.alarm_kind = ric_pkg::ALARM_VEHICLE;
        lrun_d = '0;
      end
    end else if (area_nxt > small_thr_q) begin
      res_new.frame_class = ric_pkg::CLASS_SMALL;
      lrun_d = '0;
      srun_d = srun_bump;
      if (srun_bump > persist_q) begin
        res_new.alarm_kind = ric_pkg::ALARM_PERSON;
        srun_d = '0;
      end
    end else begin
      res_new.frame_class = ric_pkg::CLASS_NONE;
      lrun_d = '0;
      srun_d = '0;
    end

    if (pix_i.data.end_of_frame) begin
      col_d  = '0;
      row_d  = '0;
      area_d = '0;
    end else begin
      col_d  = wrap ? '0 : col_inc[CW-1:0];
      row_d  = (wrap && !row_last) ? row_q + 1'b1 : row_q;
      area_d = area_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      area_q <= '0;
      lrun_q <= '0;
      srun_q <= '0;
    end else if (pix_acc) begin
      col_q  <= col_d;
      row_q  <= row_d;
      area_q <= area_d;
      if (pix_i.data.end_of_frame) begin
        lrun_q <= lrun_d;
        srun_q <= srun_d;
      end
    end
  end

  // Output register with one skid entry behind it. Ready is low whenever
  // the skid entry is full, so a new result never meets a full skid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || eof_acc;
      skid_valid_q <= 1'b0;
    end else if (eof_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_new;
    end else if (eof_acc) begin
      skid_q <= res_new;
    end
  end

  `RIC_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid entry full while output empty")
  `RIC_ASSERT(a_alarm_matches_class, !out_valid_q || out_q.alarm_kind == ric_pkg::ALARM_NONE || out_q.alarm_kind == out_q.frame_class, "alarm kind disagrees with frame class")
  `RIC_ASSERT(a_area_capped, area_q <= ric_pkg::AREA_CAP, "area count beyond its cap")
  `RIC_ASSERT_NEXT(a_eof_restarts_frame, eof_acc, col_q == '0 && row_q == '0 && area_q == '0, "frame state not cleared after end of frame")
  `RIC_ASSERT_NEXT(a_none_clears_runs, eof_acc && res_new.frame_class == ric_pkg::CLASS_NONE, lrun_q == '0 && srun_q == '0, "run counts kept after an empty frame")

endmodule
